@@ sv/ppc_dform_load_store_execute_top_assert.svh @@
// Assertion shorthands for the load/store unit; clk and rst_n come from the enclosing module.
`ifndef PPC_DFORM_LOAD_STORE_EXECUTE_TOP_ASSERT_SVH
`define PPC_DFORM_LOAD_STORE_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication.
`define PPCLS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPCLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ppcls_pkg.sv @@
package ppcls_pkg;

    localparam int MEM_BYTES_DEF = 4096;

    // Command codes
    localparam logic [2:0] CMD_EXEC    = 3'd0;
    localparam logic [2:0] CMD_WR_REG  = 3'd1;
    localparam logic [2:0] CMD_RD_REG  = 3'd2;
    localparam logic [2:0] CMD_WR_BYTE = 3'd3;
    localparam logic [2:0] CMD_RD_BYTE = 3'd4;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;

    // Primary opcodes with the update bit cleared
    localparam logic [5:0] OP_LWZ = 6'd32;
    localparam logic [5:0] OP_LBZ = 6'd34;
    localparam logic [5:0] OP_STW = 6'd36;
    localparam logic [5:0] OP_STB = 6'd38;
    localparam logic [5:0] OP_LHZ = 6'd40;
    localparam logic [5:0] OP_STH = 6'd44;

    typedef struct packed {
        logic       latch;
        logic       rd_base;
        logic       calc_ea;
        logic       check;
        logic       mem_en;
        logic [1:0] cnt;
        logic       wr_data;
        logic       wr_upd;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic       is_exec;
        logic       is_rd_reg;
        logic       is_wr_reg;
        logic       mem_rd;
        logic       upd;
        logic [1:0] nm1;
        logic       chk_ok;
        logic       ok;
    } dp_stat_t;

endpackage

@@ sv/ppcls_dp.sv @@
module ppcls_dp #(
    parameter int MEM_BYTES = ppcls_pkg::MEM_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         cmd,
    input  logic [31:0]        instruction_word,
    input  logic [4:0]         reg_index,
    input  logic [31:0]        write_value,
    input  logic [11:0]        byte_address,
    input  ppcls_pkg::dp_cmd_t ctl,
    output ppcls_pkg::dp_stat_t stat,
    output logic [31:0]        read_data,
    output logic [31:0]        effective_address,
    output logic [1:0]         status
);
    import ppcls_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    logic [2:0]    cmd_reg;
    logic [31:0]   insn_reg;
    logic [4:0]    ri_reg;
    logic [31:0]   wv_reg;
    logic [11:0]   ba_reg;
    logic [31:0]   gpr_q_reg;
    logic [31:0]   sdata_reg;
    logic [31:0]   ea_reg;
    logic [1:0]    status_reg;
    logic [31:0]   load_reg;
    logic [7:0]    mem_q_reg;
    logic          shift_en_reg;
    logic [31:0]   gpr_reg [32];
    logic [7:0]    data_mem_reg [MEM_BYTES];
    logic [31:0]   rdata_out_reg;
    logic [31:0]   ea_out_reg;
    logic [1:0]    status_out_reg;

    logic          is_exec;
    logic          is_rd_reg;
    logic          is_wr_reg;
    logic          is_rd_byte;
    logic          is_byte;
    logic [5:0]    op;
    logic [4:0]    rd;
    logic [4:0]    ra;
    logic [31:0]   disp;
    logic          supported;
    logic          is_load;
    logic [1:0]    op_nm1;
    logic [1:0]    nm1;
    logic          mem_rd;
    logic          ba_ok;
    logic          fits;
    logic [1:0]    chk_status;
    logic [31:0]   ea_next;
    logic [4:0]    gpr_raddr;
    logic [31:0]   gpr_rdata;
    logic          gpr_we;
    logic [4:0]    gpr_waddr;
    logic [31:0]   gpr_wdata;
    logic [AW-1:0] mem_addr;
    logic [1:0]    bidx;
    logic [31:0]   wsrc;
    logic [7:0]    wbyte;
    logic          mem_we;
    logic          mem_re;

    assign is_exec    = (cmd_reg == CMD_EXEC);
    assign is_rd_reg  = (cmd_reg == CMD_RD_REG);
    assign is_wr_reg  = (cmd_reg == CMD_WR_REG);
    assign is_rd_byte = (cmd_reg == CMD_RD_BYTE);
    assign is_byte    = (cmd_reg == CMD_WR_BYTE) || is_rd_byte;

    assign op   = insn_reg[31:26];
    assign rd   = insn_reg[25:21];
    assign ra   = insn_reg[20:16];
    assign disp = {{16{insn_reg[15]}}, insn_reg[15:0]};

    always_comb
    begin
        supported = 1'b1;
        is_load   = 1'b0;
        op_nm1    = 2'd0;
        unique case ({op[5:1], 1'b0})
            OP_LWZ:
            begin
                op_nm1  = 2'd3;
                is_load = 1'b1;
            end
            OP_LBZ:
            begin
                op_nm1  = 2'd0;
                is_load = 1'b1;
            end
            OP_LHZ:
            begin
                op_nm1  = 2'd1;
                is_load = 1'b1;
            end
            OP_STW: op_nm1 = 2'd3;
            OP_STB: op_nm1 = 2'd0;
            OP_STH: op_nm1 = 2'd1;
            default: supported = 1'b0;
        endcase
    end

    assign nm1    = is_exec ? op_nm1 : 2'd0;
    assign mem_rd = (is_exec && is_load) || is_rd_byte;

    // Access of nm1+1 bytes must end inside memory, no wrap.
    assign fits  = (33'(ea_reg) + 33'(nm1) + 33'd1) <= 33'(MEM_BYTES);
    assign ba_ok = 32'(ba_reg) < 32'(MEM_BYTES);

    always_comb
    begin
        if (is_exec)
        begin
            if (!supported)
                chk_status = ST_UNSUP;
            else
                chk_status = fits ? ST_DONE : ST_INVALID;
        end
        else if (is_byte)
        begin
            chk_status = ba_ok ? ST_DONE : ST_INVALID;
        end
        else
        begin
            chk_status = ST_UNSUP;
        end
    end

    assign ea_next = ((ra == 5'd0) ? 32'd0 : gpr_q_reg) + disp;

    // Register file: one read and one write port
    assign gpr_raddr = ctl.calc_ea ? rd : (is_exec ? ra : ri_reg);
    assign gpr_rdata = gpr_reg[gpr_raddr];
    assign gpr_we    = ctl.wr_data || ctl.wr_upd;
    assign gpr_waddr = ctl.wr_upd ? ra : (is_exec ? rd : ri_reg);
    assign gpr_wdata = ctl.wr_upd ? ea_reg : (is_exec ? load_reg : wv_reg);

    // Byte memory: big-endian, most significant byte at the lowest address
    assign mem_addr = is_exec ? AW'(ea_reg + 32'(ctl.cnt)) : AW'(ba_reg);
    assign bidx     = nm1 - ctl.cnt;
    assign wsrc     = is_exec ? sdata_reg : wv_reg;
    assign wbyte    = wsrc[{bidx, 3'b000} +: 8];
    assign mem_we   = ctl.mem_en && !mem_rd;
    assign mem_re   = ctl.mem_en && mem_rd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            data_mem_reg[mem_addr] <= wbyte;
        if (mem_re)
            mem_q_reg <= data_mem_reg[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_reg      <= '{default: '0};
            shift_en_reg <= 1'b0;
        end
        else
        begin
            shift_en_reg <= mem_re;
            if (gpr_we)
                gpr_reg[gpr_waddr] <= gpr_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg    <= cmd;
            insn_reg   <= instruction_word;
            ri_reg     <= reg_index;
            wv_reg     <= write_value;
            ba_reg     <= byte_address;
            ea_reg     <= '0;
            status_reg <= ST_DONE;
            load_reg   <= '0;
        end
        else
        begin
            if (ctl.rd_base)
                gpr_q_reg <= gpr_rdata;
            if (ctl.calc_ea)
            begin
                ea_reg    <= ea_next;
                sdata_reg <= gpr_rdata;
            end
            if (ctl.check)
                status_reg <= chk_status;
            // Shift in one byte per cycle, in the cycle after its read
            if (shift_en_reg)
                load_reg <= {load_reg[23:0], mem_q_reg};
        end
        if (ctl.load_out)
        begin
            rdata_out_reg  <= is_rd_reg ? gpr_q_reg : load_reg;
            ea_out_reg     <= ea_reg;
            status_out_reg <= status_reg;
        end
    end

    assign stat.is_exec   = is_exec;
    assign stat.is_rd_reg = is_rd_reg;
    assign stat.is_wr_reg = is_wr_reg;
    assign stat.mem_rd    = mem_rd;
    assign stat.upd       = is_exec && op[0];
    assign stat.nm1       = nm1;
    assign stat.chk_ok    = (chk_status == ST_DONE);
    assign stat.ok        = (status_reg == ST_DONE);

    assign read_data         = rdata_out_reg;
    assign effective_address = ea_out_reg;
    assign status            = status_out_reg;

endmodule

@@ sv/ppcls_ctrl.sv @@
module ppcls_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ppcls_pkg::dp_stat_t stat,
    output ppcls_pkg::dp_cmd_t  ctl
);
    import ppcls_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RDBASE = 9'b000000010,
        S_EA     = 9'b000000100,
        S_CHECK  = 9'b000001000,
        S_MEM    = 9'b000010000,
        S_DRAIN  = 9'b000100000,
        S_WB     = 9'b001000000,
        S_UPD    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        ctl        = '0;
        ctl.cnt    = cnt_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_RDBASE;
                end
            end
            S_RDBASE:
            begin
                ctl.rd_base = 1'b1;
                if (stat.is_exec)
                    state_next = S_EA;
                else if (stat.is_rd_reg)
                    state_next = S_OUT;
                else if (stat.is_wr_reg)
                    state_next = S_WB;
                else
                    state_next = S_CHECK;
            end
            S_EA:
            begin
                ctl.calc_ea = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.check = 1'b1;
                cnt_next  = 2'd0;
                state_next = stat.chk_ok ? S_MEM : S_OUT;
            end
            S_MEM:
            begin
                ctl.mem_en = 1'b1;
                if (cnt_reg == stat.nm1)
                begin
                    if (stat.mem_rd)
                        state_next = S_DRAIN;
                    else
                        state_next = stat.upd ? S_UPD : S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = stat.is_exec ? S_WB : S_OUT;
            end
            S_WB:
            begin
                ctl.wr_data = 1'b1;
                state_next  = stat.upd ? S_UPD : S_OUT;
            end
            S_UPD:
            begin
                ctl.wr_upd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || ctl.load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ sv/ppc_dform_load_store_execute_top.sv @@
// An execute word reads its base, forms the address, checks it, then accesses memory;
// loads then write the target register and update forms write the base register back.
// One word in flight; the next is taken the cycle after its result is registered.
// Execute accesses go through the single-port byte memory, one byte per cycle.
// Reset clears the control and all 32 registers; memory holds no defined value until written.
module ppc_dform_load_store_execute_top #(
    parameter int MEM_BYTES = ppcls_pkg::MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] instruction_word,
    input  logic [4:0]  reg_index,
    input  logic [31:0] write_value,
    input  logic [11:0] byte_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [31:0] effective_address,
    output logic [1:0]  status
);
    import ppcls_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    ppcls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    ppcls_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .instruction_word  (instruction_word),
        .reg_index         (reg_index),
        .write_value       (write_value),
        .byte_address      (byte_address),
        .ctl               (ctl),
        .stat              (stat),
        .read_data         (read_data),
        .effective_address (effective_address),
        .status            (status)
    );

`include "ppc_dform_load_store_execute_top_assert.svh"

    `PPCLS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready,
        "input taken while a word is in flight")
    `PPCLS_ASSERT_IMP(a_out_no_overwrite, ctl.load_out, !out_valid || out_ready,
        "result register overwritten before it was taken")
    `PPCLS_ASSERT_IMP(a_mem_only_when_ok, ctl.mem_en || ctl.wr_upd, stat.ok,
        "memory or update access after a failed check")
    `PPCLS_ASSERT_IMP(a_unsup_no_data, out_valid && (status == ST_UNSUP), read_data == 32'd0,
        "unsupported word returned read data")

endmodule

@@ tb/ppc_dform_load_store_execute_top_tb.sv @@
`timescale 1ns / 1ps

module ppc_dform_load_store_execute_top_tb;

    import ppcls_pkg::*;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] insn;
        logic [4:0]  ridx;
        logic [31:0] wval;
        logic [11:0] baddr;
    } lsu_word_t;

    typedef struct packed {
        logic [31:0] data;
        logic [31:0] ea;
        logic [1:0]  st;
    } lsu_result_t;

    localparam logic [5:0] UPD_BIT = 6'd1;

    class lsu_mirror;
        logic [31:0] gpr [32];
        logic [7:0]  mem [MEM_BYTES_DEF];
        bit          written [MEM_BYTES_DEF];
        lsu_result_t awaited [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned n_loads;
        int unsigned n_stores;
        int unsigned n_addr_rej;
        int unsigned n_unsup;
        int unsigned n_side;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function logic [31:0] ea_of(logic [31:0] insn);
            logic [31:0] disp;
            disp = {{16{insn[15]}}, insn[15:0]};
            return (insn[20:16] == 5'd0) ? disp : gpr[insn[20:16]] + disp;
        endfunction

        // access size in bytes, zero for anything outside the twelve loads and stores
        function int unsigned span_of(logic [5:0] op);
            case (op & ~UPD_BIT)
                OP_LWZ, OP_STW: return 4;
                OP_LHZ, OP_STH: return 2;
                OP_LBZ, OP_STB: return 1;
                default:        return 0;
            endcase
        endfunction

        function bit is_load(logic [5:0] op);
            logic [5:0] base;
            base = op & ~UPD_BIT;
            return base == OP_LWZ || base == OP_LHZ || base == OP_LBZ;
        endfunction

        // no wrap past the top of the address space
        function bit fits(logic [31:0] ea, int unsigned nb);
            return ({1'b0, ea} + 33'(nb)) <= 33'(MEM_BYTES_DEF);
        endfunction

        function void note_word(lsu_word_t w);
            lsu_result_t r;
            logic [5:0]  op;
            logic [4:0]  rt;
            logic [4:0]  ra;
            int unsigned nb;
            r = '0;
            op = w.insn[31:26];
            rt = w.insn[25:21];
            ra = w.insn[20:16];
            case (w.cmd)
                CMD_EXEC:
                begin
                    nb = span_of(op);
                    r.ea = ea_of(w.insn);
                    if (nb == 0)
                        r.st = ST_UNSUP;
                    else if (!fits(r.ea, nb))
                        r.st = ST_INVALID;
                    else
                    begin
                        if (is_load(op))
                        begin
                            for (int i = 0; i < nb; i++)
                                r.data = (r.data << 8) | 32'(mem[r.ea + i]);
                            gpr[rt] = r.data;
                            n_loads++;
                        end
                        else
                        begin
                            for (int i = 0; i < nb; i++)
                            begin
                                mem[r.ea + i] = 8'(gpr[rt] >> (8 * (nb - 1 - i)));
                                written[r.ea + i] = 1'b1;
                            end
                            n_stores++;
                        end
                        // base write-back comes last, so it wins over a load
                        // into the same register
                        if ((op & UPD_BIT) != 0)
                            gpr[ra] = r.ea;
                    end
                end
                CMD_WR_REG:
                    gpr[w.ridx] = w.wval;
                CMD_RD_REG:
                    r.data = gpr[w.ridx];
                CMD_WR_BYTE:
                begin
                    if (w.baddr < MEM_BYTES_DEF)
                    begin
                        mem[w.baddr] = w.wval[7:0];
                        written[w.baddr] = 1'b1;
                    end
                    else
                        r.st = ST_INVALID;
                end
                CMD_RD_BYTE:
                begin
                    if (w.baddr < MEM_BYTES_DEF)
                        r.data = {24'd0, mem[w.baddr]};
                    else
                        r.st = ST_INVALID;
                end
                default:
                    r.st = ST_UNSUP;
            endcase
            if (r.st == ST_INVALID)
                n_addr_rej++;
            else if (r.st == ST_UNSUP)
                n_unsup++;
            if (w.cmd != CMD_EXEC)
                n_side++;
            awaited.push_back(r);
        endfunction

        function void check_result(lsu_result_t got);
            lsu_result_t want;
            bit          bad;
            checked++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: word with nothing pending: data=%h ea=%h status=%0d",
                             $time, got.data, got.ea, got.st);
                return;
            end
            want = awaited.pop_front();
            bad = 1'b0;
            if (got.data !== want.data)
            begin
                bad = 1'b1;
                if (errors < 100)
                    $display("%0t: read_data expected %h got %h", $time, want.data,
                             got.data);
            end
            if (got.ea !== want.ea)
            begin
                bad = 1'b1;
                if (errors < 100)
                    $display("%0t: effective_address expected %h got %h", $time,
                             want.ea, got.ea);
            end
            if (got.st !== want.st)
            begin
                bad = 1'b1;
                if (errors < 100)
                    $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
            end
            if (bad)
                errors++;
        endfunction
    endclass

    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam logic [5:0] OP_LHA = 6'd42;
    localparam logic [5:0] OP_LMW = 6'd46;
    localparam logic [5:0] OP_STMW = 6'd47;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int WORDS_PER_PHASE = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [31:0] instruction_word;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic [11:0] byte_address;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic [31:0] effective_address;
    logic [1:0]  status;

    lsu_mirror   mirror = new();
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned words_sent;
    int unsigned cycles;
    bit          hold_req;

    ppc_dform_load_store_execute_top #(
        .MEM_BYTES(MEM_BYTES_DEF)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .instruction_word(instruction_word),
        .reg_index(reg_index),
        .write_value(write_value),
        .byte_address(byte_address),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .effective_address(effective_address),
        .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, mirror.awaited.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // outputs settle after the rising edge; a handshake seen here completes at the next one
    always @(negedge clk)
        if (rst_n && out_valid && out_ready)
            mirror.check_result(lsu_result_t'({read_data, effective_address, status}));

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] d_form(logic [5:0] op, logic [4:0] rt, logic [4:0] ra,
                                           logic [15:0] d);
        return {op, rt, ra, d};
    endfunction

    function automatic logic [11:0] byte_spot();
        case ($urandom_range(0, 2))
            0:       return 12'($urandom_range(0, 127));
            1:       return 12'(MEM_BYTES_DEF - 1 - $urandom_range(0, 15));
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic send_word(lsu_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= w.cmd;
        instruction_word <= w.insn;
        reg_index <= w.ridx;
        write_value <= w.wval;
        byte_address <= w.baddr;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        mirror.note_word(w);
        words_sent++;
    endtask

    task automatic send_side(logic [2:0] c, logic [4:0] idx, logic [31:0] val,
                             logic [11:0] addr);
        // never read a byte that holds no data yet
        if (c == CMD_RD_BYTE && addr < MEM_BYTES_DEF && !mirror.written[addr])
            send_word('{CMD_WR_BYTE, $urandom, 5'($urandom), $urandom, addr});
        send_word('{c, $urandom, idx, val, addr});
    endtask

    task automatic send_exec(logic [31:0] insn);
        logic [31:0] ea;
        int unsigned nb;
        ea = mirror.ea_of(insn);
        nb = mirror.span_of(insn[31:26]);
        if (nb != 0 && mirror.is_load(insn[31:26]) && mirror.fits(ea, nb))
            for (int i = 0; i < nb; i++)
                if (!mirror.written[ea + i])
                    send_word('{CMD_WR_BYTE, $urandom, 5'($urandom), $urandom, 12'(ea + i)});
        send_word('{CMD_EXEC, insn, 5'($urandom), $urandom, 12'($urandom)});
    endtask

    // aim a load or store at a chosen address, loading a base register when needed
    task automatic gen_access();
        logic [5:0]  op;
        logic [4:0]  rt;
        logic [4:0]  ra;
        logic [31:0] target;
        logic [31:0] disp;
        int unsigned nb;
        int unsigned pick;
        case ($urandom_range(0, 5))
            0:       op = OP_LWZ;
            1:       op = OP_LBZ;
            2:       op = OP_LHZ;
            3:       op = OP_STW;
            4:       op = OP_STB;
            default: op = OP_STH;
        endcase
        if ($urandom_range(0, 1))
            op = op | UPD_BIT;
        nb = mirror.span_of(op);
        rt = 5'($urandom);
        ra = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            target = $urandom_range(0, 127);
        else if (pick < 50)
            target = MEM_BYTES_DEF - nb - $urandom_range(0, 8);
        else if (pick < 75)
            target = $urandom_range(0, MEM_BYTES_DEF - nb);
        else if (pick < 85)
            target = MEM_BYTES_DEF - nb + $urandom_range(1, nb + 2);
        else if (pick < 95)
            target = $urandom;
        else
            target = 32'hFFFF_FFFF - $urandom_range(0, 3);
        // a zero base field reaches only what the displacement alone can express
        if (ra == 5'd0 && target[31:15] != '0 && target[31:15] != '1)
            ra = 5'($urandom_range(1, 31));
        if (ra == 5'd0)
            disp = target;
        else
        begin
            disp = target - mirror.gpr[ra];
            if ($urandom_range(0, 1) || !(disp[31:15] == '0 || disp[31:15] == '1))
            begin
                disp[15:0] = 16'($urandom);
                disp[31:16] = {16{disp[15]}};
                send_side(CMD_WR_REG, ra, target - disp, 12'($urandom));
            end
        end
        send_exec(d_form(op, rt, ra, disp[15:0]));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mirror.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned stop;
        int unsigned roll;
        stop = words_sent + count;
        while (words_sent < stop)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                gen_access();
            else if (roll < 62)
                send_exec($urandom);
            else if (roll < 72)
                send_side(CMD_WR_REG, 5'($urandom),
                          $urandom_range(0, 1) ? 32'($urandom_range(0, MEM_BYTES_DEF - 1))
                                               : 32'($urandom),
                          12'($urandom));
            else if (roll < 80)
                send_side(CMD_RD_REG, 5'($urandom), $urandom, 12'($urandom));
            else if (roll < 89)
                send_side(CMD_WR_BYTE, 5'($urandom), $urandom, byte_spot());
            else if (roll < 97)
                send_side(CMD_RD_BYTE, 5'($urandom), $urandom, byte_spot());
            else
                send_side(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)), 5'($urandom), $urandom,
                          12'($urandom));
            if ($urandom_range(0, 199) == 0)
                drain();
        end
    endtask

    initial
    begin
        in_valid <= 1'b0;
        cmd <= CMD_EXEC;
        instruction_word <= '0;
        reg_index <= '0;
        write_value <= '0;
        byte_address <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_side(CMD_RD_REG, 5'd0, $urandom, 12'($urandom));
        send_side(CMD_RD_REG, 5'd31, $urandom, 12'($urandom));
        send_side(CMD_WR_REG, 5'd31, 32'hFFFF_FFFF, 12'($urandom));
        send_side(CMD_WR_REG, 5'd1, 32'h0000_0100, 12'($urandom));
        send_exec(d_form(OP_STW, 5'd31, 5'd1, 16'h0000));
        send_exec(d_form(OP_LWZ, 5'd2, 5'd1, 16'h0000));
        send_side(CMD_WR_BYTE, 5'($urandom), 32'hFFFF_FFA5, 12'hFFF);
        send_side(CMD_RD_BYTE, 5'($urandom), $urandom, 12'hFFF);
        send_exec(d_form(OP_LBZ, 5'd3, 5'd0, 16'h0FFF));
        // halfword over the top byte: rejected
        send_exec(d_form(OP_LHZ, 5'd4, 5'd0, 16'h0FFF));
        send_exec(d_form(OP_LWZ, 5'd4, 5'd0, 16'h0FFC));
        send_exec(d_form(OP_LWZ, 5'd5, 5'd0, 16'hFFFF));
        send_exec(d_form(OP_STW | UPD_BIT, 5'd31, 5'd1, 16'h0004));
        // update with a zero base field lands in r0
        send_exec(d_form(OP_STH | UPD_BIT, 5'd2, 5'd0, 16'h0002));
        // update load into its own base: the address wins
        send_exec(d_form(OP_LWZ | UPD_BIT, 5'd1, 5'd1, 16'hFFFC));
        send_exec(d_form(OP_STB | UPD_BIT, 5'd31, 5'd1, 16'h0010));
        send_exec(d_form(OP_LBZ | UPD_BIT, 5'd6, 5'd1, 16'hFFF0));
        send_exec(d_form(OP_LHZ | UPD_BIT, 5'd7, 5'd1, 16'h0002));
        send_exec(d_form(OP_STB, 5'd2, 5'd0, 16'h0000));
        send_exec(d_form(OP_STH, 5'd31, 5'd0, 16'h0FFE));
        send_exec(d_form(OP_LHA, 5'd8, 5'd1, 16'h0000));
        send_exec(d_form(OP_LMW, 5'd8, 5'd1, 16'h0000));
        send_exec(d_form(OP_STMW, 5'd8, 5'd1, 16'h0000));
        send_exec(32'h0000_0000);
        send_exec(32'hFFFF_FFFF);
        send_side(CMD_BAD_LO, 5'($urandom), $urandom, 12'($urandom));
        send_side(CMD_BAD_HI, 5'($urandom), $urandom, 12'($urandom));
        drain();

        // back-to-back, with one long output hold that backs the input up
        run_random(100);
        hold_req = 1'b1;
        run_random(WORDS_PER_PHASE - 100);
        drain();

        send_idle_pct = 87;
        run_random(WORDS_PER_PHASE);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 87;
        run_random(WORDS_PER_PHASE);
        drain();

        send_idle_pct = 38;
        recv_stall_pct = 38;
        run_random(WORDS_PER_PHASE);
        drain();

        $display("%0d words: %0d loads and %0d stores done, %0d address rejects, %0d unsupported,"
                 , words_sent, mirror.n_loads, mirror.n_stores, mirror.n_addr_rej,
                 mirror.n_unsup);
        $display("%0d register/byte commands; %0d results checked in %0d cycles, %0d bad",
                 mirror.n_side, mirror.checked, cycles, mirror.errors);
        if (mirror.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
